### hw/rtl/elevator_door_floor_fsm_macros.svh
// ----------------------------------------------------------------------------
// Elevator controller assertion macros
// Concurrent assertion wrappers that drop out in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_DOOR_FLOOR_FSM_MACROS_SVH
`define ELEVATOR_DOOR_FLOOR_FSM_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define EDF_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("elevator controller assertion failed");

// Property checked on every rising clock edge, reset included.
`define EDF_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) (prop)) \
		else $error("elevator controller assertion failed");

`else

`define EDF_ASSERT(name, prop)
`define EDF_ASSERT_ALWAYS(name, prop)

`endif

`endif

### hw/rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// Elevator controller package
// State and command codes, event numbers, lamp bits and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

	// Controller states, numbered in entry table order.
	typedef enum logic [4:0] {
		S_OFF       = 5'd0,
		S_INIT      = 5'd1,
		S_FL2       = 5'd2,
		S_FL3       = 5'd3,
		S_FL4       = 5'd4,
		S_UP3       = 5'd5,
		S_DN3       = 5'd6,
		S_UP4       = 5'd7,
		S_DN2       = 5'd8,
		S_D2OPENING = 5'd9,
		S_D2OPEN    = 5'd10,
		S_D2CLOSING = 5'd11,
		S_D2CLOSED  = 5'd12,
		S_D3OPENING = 5'd13,
		S_D3OPEN    = 5'd14,
		S_D3CLOSING = 5'd15,
		S_D3CLOSED  = 5'd16,
		S_D4OPENING = 5'd17,
		S_D4OPEN    = 5'd18,
		S_D4CLOSING = 5'd19,
		S_D4CLOSED  = 5'd20,
		S_MVUP      = 5'd21,
		S_MVDN      = 5'd22,
		S_CAB25     = 5'd23,
		S_CAB35     = 5'd24
	} state_t;

	// Motor and door commands.
	typedef enum logic [2:0] {
		CMD_OFF   = 3'd0,
		CMD_OPEN  = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_UP    = 3'd3,
		CMD_DOWN  = 3'd4
	} cmd_t;

	// Event numbers.
	localparam logic [4:0] EV_TIMER      = 5'd0;
	localparam logic [4:0] EV_POWER_ON   = 5'd1;
	localparam logic [4:0] EV_DOOR_OPEN  = 5'd2;
	localparam logic [4:0] EV_DOOR_SHUT  = 5'd3;
	localparam logic [4:0] EV_DOOR_OBST  = 5'd4;
	localparam logic [4:0] EV_CAB_2      = 5'd5;
	localparam logic [4:0] EV_CAB_25     = 5'd6;
	localparam logic [4:0] EV_CAB_3      = 5'd7;
	localparam logic [4:0] EV_CAB_35     = 5'd8;
	localparam logic [4:0] EV_CAB_4      = 5'd9;
	localparam logic [4:0] EV_CALL_2     = 5'd10;
	localparam logic [4:0] EV_CALL_3     = 5'd11;
	localparam logic [4:0] EV_CALL_4     = 5'd12;
	localparam logic [4:0] EV_REQ_OPEN   = 5'd13;
	localparam logic [4:0] EV_REQ_STOP   = 5'd14;
	localparam logic [4:0] EV_REQ_2      = 5'd15;
	localparam logic [4:0] EV_REQ_3      = 5'd16;
	localparam logic [4:0] EV_REQ_4      = 5'd17;
	localparam logic [4:0] EV_BELL_PRESS = 5'd18;
	localparam logic [4:0] EV_BELL_REL   = 5'd19;
	localparam logic [4:0] EV_LAST       = EV_BELL_REL;

	// Item modes.
	localparam logic MODE_EVENT = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_FLOOR_DWELL = 1'b0;
	localparam logic CFG_DOOR_OPEN   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [7:0] FLOOR_DWELL_RESET = 8'd10;
	localparam logic [7:0] DOOR_OPEN_RESET   = 8'd5;

	// Lamp bits, one group of three per function, floors 2, 3 and 4.
	localparam logic [14:0] LAMP_CAB2  = 15'h0001;
	localparam logic [14:0] LAMP_CAB3  = 15'h0002;
	localparam logic [14:0] LAMP_CAB4  = 15'h0004;
	localparam logic [14:0] LAMP_POS2  = 15'h0008;
	localparam logic [14:0] LAMP_POS3  = 15'h0010;
	localparam logic [14:0] LAMP_POS4  = 15'h0020;
	localparam logic [14:0] LAMP_REQ2  = 15'h0040;
	localparam logic [14:0] LAMP_REQ3  = 15'h0080;
	localparam logic [14:0] LAMP_REQ4  = 15'h0100;
	localparam logic [14:0] LAMP_CALL2 = 15'h0200;
	localparam logic [14:0] LAMP_CALL3 = 15'h0400;
	localparam logic [14:0] LAMP_CALL4 = 15'h0800;
	localparam logic [14:0] LAMP_BUSY2 = 15'h1000;
	localparam logic [14:0] LAMP_BUSY3 = 15'h2000;
	localparam logic [14:0] LAMP_BUSY4 = 15'h4000;
	localparam logic [14:0] LAMP_ALL   = 15'h7FFF;

	// Input word.
	typedef struct packed {
		logic       mode;
		logic [4:0] event_code;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [4:0]  current_state;
		logic        moved;
		logic        cmd_valid;
		logic [2:0]  motor_cmd;
		logic [14:0] indicator_word;
	} out_word_t;

	// Architectural state carried between items.
	typedef struct packed {
		state_t      fsm_state;
		logic [7:0]  countdown;
		logic [14:0] lamp_word;
	} ctx_t;

	// Result of a transition table lookup.
	typedef struct packed {
		logic   hit;
		state_t nxt;
	} move_t;

endpackage

`default_nettype wire

### hw/rtl/edf_step.sv
// ----------------------------------------------------------------------------
// Elevator controller step logic
// Timer tick, transition table lookup and entry action for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_step (
	input  wire edf_pkg::ctx_t     ctx,
	input  wire edf_pkg::in_word_t item,
	input  wire logic [7:0]        floor_dwell_ticks,
	input  wire logic [7:0]        door_open_ticks,
	output edf_pkg::ctx_t          ctx_nxt,
	output edf_pkg::out_word_t     result
);

	// Transition table: next state for a state and event, or no move.
	function automatic edf_pkg::move_t lookup(edf_pkg::state_t s, logic [4:0] e);
		edf_pkg::move_t m;
		m.hit = 1'b1;
		m.nxt = edf_pkg::S_OFF;
		unique case (s)
			edf_pkg::S_OFF: begin
				if (e == edf_pkg::EV_POWER_ON) m.nxt = edf_pkg::S_INIT;
				else m.hit = 1'b0;
			end
			edf_pkg::S_INIT, edf_pkg::S_FL2: begin
				priority if (e == edf_pkg::EV_TIMER)
					m.nxt = (s == edf_pkg::S_INIT) ? edf_pkg::S_FL2 : edf_pkg::S_D2CLOSED;
				else if (e == edf_pkg::EV_CALL_3 || e == edf_pkg::EV_REQ_3)
					m.nxt = edf_pkg::S_UP3;
				else if (e == edf_pkg::EV_CALL_4 || e == edf_pkg::EV_REQ_4)
					m.nxt = edf_pkg::S_UP4;
				else m.hit = 1'b0;
			end
			edf_pkg::S_FL3: begin
				priority if (e == edf_pkg::EV_TIMER) m.nxt = edf_pkg::S_D3CLOSED;
				else if (e == edf_pkg::EV_CALL_2 || e == edf_pkg::EV_REQ_2)
					m.nxt = edf_pkg::S_DN2;
				else if (e == edf_pkg::EV_CALL_4 || e == edf_pkg::EV_REQ_4)
					m.nxt = edf_pkg::S_UP4;
				else m.hit = 1'b0;
			end
			edf_pkg::S_FL4: begin
				priority if (e == edf_pkg::EV_TIMER) m.nxt = edf_pkg::S_D4CLOSED;
				else if (e == edf_pkg::EV_CALL_2 || e == edf_pkg::EV_REQ_2)
					m.nxt = edf_pkg::S_DN2;
				else if (e == edf_pkg::EV_CALL_3 || e == edf_pkg::EV_REQ_3)
					m.nxt = edf_pkg::S_DN3;
				else m.hit = 1'b0;
			end
			edf_pkg::S_UP3, edf_pkg::S_DN3: begin
				if (e == edf_pkg::EV_CAB_3) m.nxt = edf_pkg::S_FL3;
				else m.hit = 1'b0;
			end
			edf_pkg::S_UP4: begin
				if (e == edf_pkg::EV_CAB_4) m.nxt = edf_pkg::S_FL4;
				else m.hit = 1'b0;
			end
			edf_pkg::S_DN2: begin
				if (e == edf_pkg::EV_CAB_2) m.nxt = edf_pkg::S_FL2;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D2OPENING: begin
				if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_D2OPEN;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D3OPENING: begin
				if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_D3OPEN;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D4OPENING: begin
				if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_D4OPEN;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D2OPEN: begin
				if (e == edf_pkg::EV_TIMER) m.nxt = edf_pkg::S_D2CLOSING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D3OPEN: begin
				if (e == edf_pkg::EV_TIMER) m.nxt = edf_pkg::S_D3CLOSING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D4OPEN: begin
				if (e == edf_pkg::EV_TIMER) m.nxt = edf_pkg::S_D4CLOSING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D2CLOSING: begin
				priority if (e == edf_pkg::EV_DOOR_SHUT) m.nxt = edf_pkg::S_D2CLOSED;
				else if (e == edf_pkg::EV_DOOR_OBST || e == edf_pkg::EV_REQ_OPEN)
					m.nxt = edf_pkg::S_D2OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D3CLOSING: begin
				priority if (e == edf_pkg::EV_DOOR_SHUT) m.nxt = edf_pkg::S_D3CLOSED;
				else if (e == edf_pkg::EV_DOOR_OBST || e == edf_pkg::EV_REQ_OPEN)
					m.nxt = edf_pkg::S_D3OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D4CLOSING: begin
				priority if (e == edf_pkg::EV_DOOR_SHUT) m.nxt = edf_pkg::S_D4CLOSED;
				else if (e == edf_pkg::EV_DOOR_OBST || e == edf_pkg::EV_REQ_OPEN)
					m.nxt = edf_pkg::S_D4OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D2CLOSED: begin
				priority if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_FL2;
				else if (e == edf_pkg::EV_CALL_3 || e == edf_pkg::EV_REQ_3)
					m.nxt = edf_pkg::S_UP3;
				else if (e == edf_pkg::EV_CALL_4 || e == edf_pkg::EV_REQ_4)
					m.nxt = edf_pkg::S_UP4;
				else if (e == edf_pkg::EV_REQ_OPEN) m.nxt = edf_pkg::S_D2OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D3CLOSED: begin
				priority if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_FL3;
				else if (e == edf_pkg::EV_CALL_2 || e == edf_pkg::EV_REQ_2)
					m.nxt = edf_pkg::S_DN2;
				else if (e == edf_pkg::EV_CALL_4 || e == edf_pkg::EV_REQ_4)
					m.nxt = edf_pkg::S_UP4;
				else if (e == edf_pkg::EV_REQ_OPEN) m.nxt = edf_pkg::S_D3OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_D4CLOSED: begin
				priority if (e == edf_pkg::EV_DOOR_OPEN) m.nxt = edf_pkg::S_FL4;
				else if (e == edf_pkg::EV_CALL_2 || e == edf_pkg::EV_REQ_2)
					m.nxt = edf_pkg::S_DN2;
				else if (e == edf_pkg::EV_CALL_3 || e == edf_pkg::EV_REQ_3)
					m.nxt = edf_pkg::S_DN3;
				else if (e == edf_pkg::EV_REQ_OPEN) m.nxt = edf_pkg::S_D4OPENING;
				else m.hit = 1'b0;
			end
			edf_pkg::S_MVUP, edf_pkg::S_MVDN: begin
				priority if (e == edf_pkg::EV_CAB_2) m.nxt = edf_pkg::S_FL2;
				else if (e == edf_pkg::EV_CAB_25) m.nxt = edf_pkg::S_CAB25;
				else if (e == edf_pkg::EV_CAB_3) m.nxt = edf_pkg::S_FL3;
				else if (e == edf_pkg::EV_CAB_35) m.nxt = edf_pkg::S_CAB35;
				else if (e == edf_pkg::EV_CAB_4) m.nxt = edf_pkg::S_FL4;
				else m.hit = 1'b0;
			end
			default: m.hit = 1'b0;
		endcase
		return m;
	endfunction

	logic [4:0]      ev;
	logic            apply;
	logic [7:0]      cnt_dec;
	edf_pkg::move_t  mv;
	logic            issued;
	edf_pkg::cmd_t   cmd;

	// Tick handling and event selection.
	always_comb begin
		cnt_dec = ctx.countdown - 8'd1;
		ev      = item.event_code;
		apply   = 1'b0;
		ctx_nxt = ctx;
		if (item.mode == edf_pkg::MODE_TICK) begin
			if (ctx.countdown != 8'd0) begin
				ctx_nxt.countdown = cnt_dec;
				if (cnt_dec == 8'd0) begin
					apply = 1'b1;
					ev    = edf_pkg::EV_TIMER;
				end
			end
		end else begin
			apply = (item.event_code <= edf_pkg::EV_LAST);
		end

		mv     = lookup(ctx.fsm_state, ev);
		issued = 1'b0;
		cmd    = edf_pkg::CMD_OFF;

		// Entry action of the state being entered.
		if (apply && mv.hit) begin
			ctx_nxt.fsm_state = mv.nxt;
			issued = 1'b1;
			unique case (mv.nxt)
				edf_pkg::S_OFF: ;
				edf_pkg::S_INIT: begin
					cmd = edf_pkg::CMD_OPEN;
					ctx_nxt.lamp_word = edf_pkg::LAMP_ALL;
					ctx_nxt.countdown = floor_dwell_ticks;
				end
				edf_pkg::S_FL2: begin
					ctx_nxt.lamp_word = edf_pkg::LAMP_CAB2 | edf_pkg::LAMP_POS2;
					ctx_nxt.countdown = floor_dwell_ticks;
				end
				edf_pkg::S_FL3: begin
					ctx_nxt.lamp_word = edf_pkg::LAMP_CAB3 | edf_pkg::LAMP_POS3;
					ctx_nxt.countdown = floor_dwell_ticks;
				end
				edf_pkg::S_FL4: begin
					ctx_nxt.lamp_word = edf_pkg::LAMP_CAB4 | edf_pkg::LAMP_POS4;
					ctx_nxt.countdown = floor_dwell_ticks;
				end
				edf_pkg::S_DN2: begin
					cmd = edf_pkg::CMD_DOWN;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_REQ2
						| edf_pkg::LAMP_CALL2 | edf_pkg::LAMP_BUSY3 | edf_pkg::LAMP_BUSY4;
				end
				edf_pkg::S_DN3: begin
					cmd = edf_pkg::CMD_DOWN;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_REQ3
						| edf_pkg::LAMP_CALL3 | edf_pkg::LAMP_BUSY4 | edf_pkg::LAMP_BUSY2;
				end
				edf_pkg::S_UP3: begin
					cmd = edf_pkg::CMD_UP;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_REQ3
						| edf_pkg::LAMP_CALL3 | edf_pkg::LAMP_BUSY2 | edf_pkg::LAMP_BUSY4;
				end
				edf_pkg::S_UP4: begin
					cmd = edf_pkg::CMD_UP;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_REQ4
						| edf_pkg::LAMP_CALL4 | edf_pkg::LAMP_BUSY2 | edf_pkg::LAMP_BUSY3;
				end
				edf_pkg::S_MVUP: cmd = edf_pkg::CMD_UP;
				edf_pkg::S_MVDN: cmd = edf_pkg::CMD_DOWN;
				edf_pkg::S_CAB25, edf_pkg::S_CAB35: issued = 1'b0;
				edf_pkg::S_D2OPENING: begin
					cmd = edf_pkg::CMD_OPEN;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS2;
				end
				edf_pkg::S_D3OPENING: begin
					cmd = edf_pkg::CMD_OPEN;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS3;
				end
				edf_pkg::S_D4OPENING: begin
					cmd = edf_pkg::CMD_OPEN;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS4;
				end
				edf_pkg::S_D2OPEN: begin
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS2;
					ctx_nxt.countdown = door_open_ticks;
				end
				edf_pkg::S_D3OPEN: begin
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS3;
					ctx_nxt.countdown = door_open_ticks;
				end
				edf_pkg::S_D4OPEN: begin
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS4;
					ctx_nxt.countdown = door_open_ticks;
				end
				edf_pkg::S_D2CLOSING: begin
					cmd = edf_pkg::CMD_CLOSE;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS2;
				end
				edf_pkg::S_D3CLOSING: begin
					cmd = edf_pkg::CMD_CLOSE;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS3;
				end
				edf_pkg::S_D4CLOSING: begin
					cmd = edf_pkg::CMD_CLOSE;
					ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS4;
				end
				edf_pkg::S_D2CLOSED: ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS2;
				edf_pkg::S_D3CLOSED: ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS3;
				edf_pkg::S_D4CLOSED: ctx_nxt.lamp_word = ctx.lamp_word | edf_pkg::LAMP_POS4;
				default: issued = 1'b0;
			endcase
		end
	end

	// Result word for this item.
	always_comb begin
		result.current_state  = ctx_nxt.fsm_state;
		result.moved          = apply & mv.hit;
		result.cmd_valid      = issued;
		result.motor_cmd      = issued ? cmd : edf_pkg::CMD_OFF;
		result.indicator_word = ctx_nxt.lamp_word;
	end

endmodule

`default_nettype wire

### hw/rtl/elevator_door_floor_fsm.sv
// Path: the input register holds the word, then the result register holds its result.
// Throughput: one word per cycle unless out_stall holds it; the step logic between
// the input and result registers updates the controller state once per word.
// Reset: arst_n low clears both pipeline valids, puts the controller in the off
// state with a zero countdown and dark lamps, and restores the timing registers.
// ----------------------------------------------------------------------------
// Elevator door and floor controller
// Table-driven three-floor elevator controller with a tick-driven timer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "elevator_door_floor_fsm_macros.svh"

module elevator_door_floor_fsm (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output logic                     in_stall,
	input  wire  edf_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire  logic               out_stall,
	output edf_pkg::out_word_t       out_word,
	input  wire  logic               cfg_valid,
	output logic                     cfg_ready,
	input  wire  logic               cfg_index,
	input  wire  logic [7:0]         cfg_data
);

	edf_pkg::in_word_t  item_s1;
	logic               valid_s1;
	edf_pkg::out_word_t out_word_q;
	logic               out_valid_q;
	edf_pkg::ctx_t      ctx_q;
	edf_pkg::ctx_t      ctx_nxt;
	edf_pkg::out_word_t result;
	logic [7:0]         floor_dwell_q;
	logic [7:0]         door_open_q;
	logic               advance;
	logic               take_in;

	// Handshake: the input register refills whenever its word moves on.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign take_in   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign cfg_ready = 1'b1;

	// Per-word step logic.
	edf_step u_step (
		.ctx               (ctx_q),
		.item              (item_s1),
		.floor_dwell_ticks (floor_dwell_q),
		.door_open_ticks   (door_open_q),
		.ctx_nxt           (ctx_nxt),
		.result            (result)
	);

	// Control state: valids, controller context and timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			ctx_q         <= '{fsm_state: edf_pkg::S_OFF, countdown: 8'd0, lamp_word: 15'd0};
			floor_dwell_q <= edf_pkg::FLOOR_DWELL_RESET;
			door_open_q   <= edf_pkg::DOOR_OPEN_RESET;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				ctx_q       <= ctx_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					edf_pkg::CFG_FLOOR_DWELL: floor_dwell_q <= cfg_data;
					edf_pkg::CFG_DOOR_OPEN:   door_open_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= in_word;
		end
		if (advance) begin
			out_word_q <= result;
		end
	end

	// A shown result always carries the controller's present state.
	`EDF_ASSERT(a_state_matches, out_valid_q |-> (out_word_q.current_state == ctx_q.fsm_state))
	// A command is only flagged on a taken transition.
	`EDF_ASSERT(a_cmd_needs_move, out_valid_q |-> (out_word_q.moved || !out_word_q.cmd_valid))
	// Without a command the motor field reads as all off.
	`EDF_ASSERT(a_cmd_off, (out_valid_q && !out_word_q.cmd_valid) |->
		(out_word_q.motor_cmd == edf_pkg::CMD_OFF))
	// The input side only stalls while a word is held.
	`EDF_ASSERT_ALWAYS(a_stall_held, in_stall |-> valid_s1)

endmodule

`default_nettype wire

### tb/elevator_door_floor_fsm_test.sv
// ----------------------------------------------------------------------------
// Elevator controller testbench
// Drives event and tick words into the controller and checks every result
// word against a local transition table and entry actions, or a typed row's want.
// Flow control on both sides and the timing registers vary over the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module elevator_door_floor_fsm_test;
	import edf_pkg::*;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          PHASE_WORDS   = 100;
	localparam int          REPORT_LIMIT  = 10;
	localparam logic [4:0]  NO_MOVE       = 5'h1F;
	localparam logic [4:0]  EV_UNUSED_TOP = 5'h1F;
	localparam out_word_t   UNTYPED       = '0;

	// One row of the directed sequence; want is only used when typed is set.
	typedef struct packed {
		in_word_t  w;
		logic      typed;
		out_word_t want;
	} vector_t;

	localparam int DIRECTED_ROWS = 28;
	localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{MODE_EVENT, EV_DOOR_SHUT}, 1'b1, '{S_OFF, 1'b0, 1'b0, CMD_OFF, 15'h0000}},
		'{'{MODE_TICK, EV_TIMER}, 1'b1, '{S_OFF, 1'b0, 1'b0, CMD_OFF, 15'h0000}},
		'{'{MODE_EVENT, EV_UNUSED_TOP}, 1'b1, '{S_OFF, 1'b0, 1'b0, CMD_OFF, 15'h0000}},
		'{'{MODE_EVENT, EV_POWER_ON}, 1'b1, '{S_INIT, 1'b1, 1'b1, CMD_OPEN, LAMP_ALL}},
		'{'{MODE_EVENT, EV_TIMER}, 1'b1,
			'{S_FL2, 1'b1, 1'b1, CMD_OFF, LAMP_CAB2 | LAMP_POS2}},
		'{'{MODE_TICK, EV_UNUSED_TOP}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_REQ_OPEN}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_DOOR_OPEN}, 1'b0, UNTYPED},
		'{'{MODE_TICK, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_TICK, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_TICK, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_TICK, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_TICK, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_DOOR_OBST}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_DOOR_OPEN}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_TIMER}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_DOOR_SHUT}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_REQ_4}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_BELL_PRESS}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_CAB_4}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_REQ_3}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_CAB_3}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_CALL_2}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_REQ_STOP}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_CAB_2}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_BELL_REL}, 1'b0, UNTYPED},
		'{'{MODE_EVENT, EV_CALL_3}, 1'b0, UNTYPED}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_stall;
	out_word_t  out_word;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	// Controller copy kept by the testbench.
	state_t      ctl_state   = S_OFF;
	logic [7:0]  ctl_timer   = '0;
	logic [14:0] ctl_lamps   = '0;
	logic [7:0]  dwell_ticks = FLOOR_DWELL_RESET;
	logic [7:0]  open_ticks  = DOOR_OPEN_RESET;

	out_word_t   pending_results [$];
	logic [24:0] states_seen = '0;
	int          fail_count = 0;
	int          words_sent = 0;
	int          live_words = 0;
	int          results_seen = 0;
	int          settings_used = 0;
	int          burst_left = 0;
	int          cycle_count = 0;

	elevator_door_floor_fsm DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Transition table: returns 1 and the next state when the event moves.
	function automatic logic find_move(input state_t s, input logic [4:0] e,
			output state_t nx);
		logic [4:0] n;
		n = NO_MOVE;
		case (s)
			S_OFF: if (e == EV_POWER_ON) n = S_INIT;
			S_INIT, S_FL2: begin
				if (e == EV_TIMER) n = (s == S_INIT) ? S_FL2 : S_D2CLOSED;
				else if (e == EV_CALL_3 || e == EV_REQ_3) n = S_UP3;
				else if (e == EV_CALL_4 || e == EV_REQ_4) n = S_UP4;
			end
			S_FL3: begin
				if (e == EV_TIMER) n = S_D3CLOSED;
				else if (e == EV_CALL_2 || e == EV_REQ_2) n = S_DN2;
				else if (e == EV_CALL_4 || e == EV_REQ_4) n = S_UP4;
			end
			S_FL4: begin
				if (e == EV_TIMER) n = S_D4CLOSED;
				else if (e == EV_CALL_2 || e == EV_REQ_2) n = S_DN2;
				else if (e == EV_CALL_3 || e == EV_REQ_3) n = S_DN3;
			end
			S_UP3, S_DN3: if (e == EV_CAB_3) n = S_FL3;
			S_UP4: if (e == EV_CAB_4) n = S_FL4;
			S_DN2: if (e == EV_CAB_2) n = S_FL2;
			S_D2OPENING, S_D3OPENING, S_D4OPENING: if (e == EV_DOOR_OPEN) n = s + 5'd1;
			S_D2OPEN, S_D3OPEN, S_D4OPEN: if (e == EV_TIMER) n = s + 5'd1;
			S_D2CLOSING, S_D3CLOSING, S_D4CLOSING: begin
				if (e == EV_DOOR_SHUT) n = s + 5'd1;
				else if (e == EV_DOOR_OBST || e == EV_REQ_OPEN) n = s - 5'd2;
			end
			S_D2CLOSED: begin
				if (e == EV_DOOR_OPEN) n = S_FL2;
				else if (e == EV_CALL_3 || e == EV_REQ_3) n = S_UP3;
				else if (e == EV_CALL_4 || e == EV_REQ_4) n = S_UP4;
				else if (e == EV_REQ_OPEN) n = S_D2OPENING;
			end
			S_D3CLOSED: begin
				if (e == EV_DOOR_OPEN) n = S_FL3;
				else if (e == EV_CALL_2 || e == EV_REQ_2) n = S_DN2;
				else if (e == EV_CALL_4 || e == EV_REQ_4) n = S_UP4;
				else if (e == EV_REQ_OPEN) n = S_D3OPENING;
			end
			S_D4CLOSED: begin
				if (e == EV_DOOR_OPEN) n = S_FL4;
				else if (e == EV_CALL_2 || e == EV_REQ_2) n = S_DN2;
				else if (e == EV_CALL_3 || e == EV_REQ_3) n = S_DN3;
				else if (e == EV_REQ_OPEN) n = S_D4OPENING;
			end
			S_MVUP, S_MVDN: begin
				if (e == EV_CAB_2) n = S_FL2;
				else if (e == EV_CAB_25) n = S_CAB25;
				else if (e == EV_CAB_3) n = S_FL3;
				else if (e == EV_CAB_35) n = S_CAB35;
				else if (e == EV_CAB_4) n = S_FL4;
			end
			default: n = NO_MOVE;
		endcase
		nx = state_t'(n);
		return n != NO_MOVE;
	endfunction

	// Advances the controller copy by one word and returns the expected result.
	function automatic out_word_t step_controller(input in_word_t w);
		logic       apply;
		logic       hit;
		logic       issued;
		logic [4:0] ev;
		cmd_t       cmd;
		state_t     nx;
		out_word_t  r;
		apply = 1'b0;
		hit = 1'b0;
		issued = 1'b0;
		ev = w.event_code;
		cmd = CMD_OFF;
		nx = ctl_state;

		// A tick only counts down; expiry turns it into the timer event.
		if (w.mode == MODE_TICK) begin
			if (ctl_timer != 0) begin
				ctl_timer = ctl_timer - 8'd1;
				if (ctl_timer == 0) begin
					apply = 1'b1;
					ev = EV_TIMER;
				end
			end
		end else if (ev <= EV_LAST) begin
			apply = 1'b1;
		end
		if (apply) hit = find_move(ctl_state, ev, nx);

		// Entry action of the new state.
		if (hit) begin
			ctl_state = nx;
			issued = 1'b1;
			case (nx)
				S_INIT: begin
					cmd = CMD_OPEN;
					ctl_lamps = LAMP_ALL;
					ctl_timer = dwell_ticks;
				end
				S_FL2: begin
					ctl_lamps = LAMP_CAB2 | LAMP_POS2;
					ctl_timer = dwell_ticks;
				end
				S_FL3: begin
					ctl_lamps = LAMP_CAB3 | LAMP_POS3;
					ctl_timer = dwell_ticks;
				end
				S_FL4: begin
					ctl_lamps = LAMP_CAB4 | LAMP_POS4;
					ctl_timer = dwell_ticks;
				end
				S_DN2: begin
					cmd = CMD_DOWN;
					ctl_lamps |= LAMP_REQ2 | LAMP_CALL2 | LAMP_BUSY3 | LAMP_BUSY4;
				end
				S_DN3: begin
					cmd = CMD_DOWN;
					ctl_lamps |= LAMP_REQ3 | LAMP_CALL3 | LAMP_BUSY4 | LAMP_BUSY2;
				end
				S_UP3: begin
					cmd = CMD_UP;
					ctl_lamps |= LAMP_REQ3 | LAMP_CALL3 | LAMP_BUSY2 | LAMP_BUSY4;
				end
				S_UP4: begin
					cmd = CMD_UP;
					ctl_lamps |= LAMP_REQ4 | LAMP_CALL4 | LAMP_BUSY2 | LAMP_BUSY3;
				end
				S_MVUP: cmd = CMD_UP;
				S_MVDN: cmd = CMD_DOWN;
				S_CAB25, S_CAB35: issued = 1'b0;
				S_D2OPENING: begin
					cmd = CMD_OPEN;
					ctl_lamps |= LAMP_POS2;
				end
				S_D3OPENING: begin
					cmd = CMD_OPEN;
					ctl_lamps |= LAMP_POS3;
				end
				S_D4OPENING: begin
					cmd = CMD_OPEN;
					ctl_lamps |= LAMP_POS4;
				end
				S_D2OPEN: begin
					ctl_timer = open_ticks;
					ctl_lamps |= LAMP_POS2;
				end
				S_D3OPEN: begin
					ctl_timer = open_ticks;
					ctl_lamps |= LAMP_POS3;
				end
				S_D4OPEN: begin
					ctl_timer = open_ticks;
					ctl_lamps |= LAMP_POS4;
				end
				S_D2CLOSING: begin
					cmd = CMD_CLOSE;
					ctl_lamps |= LAMP_POS2;
				end
				S_D3CLOSING: begin
					cmd = CMD_CLOSE;
					ctl_lamps |= LAMP_POS3;
				end
				S_D4CLOSING: begin
					cmd = CMD_CLOSE;
					ctl_lamps |= LAMP_POS4;
				end
				S_D2CLOSED: ctl_lamps |= LAMP_POS2;
				S_D3CLOSED: ctl_lamps |= LAMP_POS3;
				S_D4CLOSED: ctl_lamps |= LAMP_POS4;
				default: cmd = CMD_OFF;
			endcase
		end

		r.current_state = ctl_state;
		r.moved = hit;
		r.cmd_valid = issued;
		r.motor_cmd = issued ? cmd : CMD_OFF;
		r.indicator_word = ctl_lamps;
		return r;
	endfunction

	// Picks the next random word; most words move the controller on.
	function automatic in_word_t next_word();
		in_word_t    w;
		state_t      nx;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		w.mode = MODE_EVENT;
		w.event_code = 5'($urandom_range(0, EV_LAST));
		if (roll < 12) begin
			w.mode = MODE_TICK;
			w.event_code = 5'($urandom_range(0, EV_UNUSED_TOP));
		end else if (roll < 22) begin
			w.event_code = 5'($urandom_range(0, EV_UNUSED_TOP));
		end else if (ctl_timer != 0 && find_move(ctl_state, EV_TIMER, nx)
				&& $urandom_range(0, 1) == 1) begin
			w.mode = MODE_TICK;
			w.event_code = 5'($urandom_range(0, EV_UNUSED_TOP));
		end else begin
			for (int i = 0; i < 10 && !find_move(ctl_state, w.event_code, nx); i++)
				w.event_code = 5'($urandom_range(0, EV_LAST));
		end
		return w;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
	endtask

	// Offers one word, waits for acceptance and queues its expected result.
	task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
		logic      live;
		out_word_t exp_word;
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		live = (w.mode == MODE_TICK && ctl_timer != 0);
		exp_word = step_controller(w);
		if (live || exp_word.moved) live_words++;
		words_sent++;
		states_seen[ctl_state] = 1'b1;
		pending_results.push_back(typed ? want : exp_word);
	endtask

	// Sender works in bursts with random gaps between them.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	// Holds the sender until every expected result has come back.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_timing(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FLOOR_DWELL) dwell_ticks = value;
		else open_ticks = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver stalls in stretches: none, light or heavy.
	initial begin
		int stretch;
		int level;
		stretch = 0;
		level = 0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(5, 60);
				level = $urandom_range(0, 2);
			end
			stretch--;
			case (level)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Result check against the oldest expected word.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result word %h", out_word));
			end else begin
				want = pending_results.pop_front();
				if (out_word !== want)
					note_failure($sformatf({"result %0d: state %0d/%0d moved %b/%b ",
						"cmd_valid %b/%b motor %0d/%0d lamps %h/%h (got/expected)"},
						results_seen, out_word.current_state, want.current_state,
						out_word.moved, want.moved, out_word.cmd_valid, want.cmd_valid,
						out_word.motor_cmd, want.motor_cmd,
						out_word.indicator_word, want.indicator_word));
			end
		end
	end

	// Main sequence: reset, directed words, then random phases.
	initial begin
		logic [7:0] dwell_set [5];
		logic [7:0] open_set [5];
		int         phase_start;
		dwell_set = '{8'd3, 8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 12))};
		open_set  = '{8'd2, 8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 12))};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FLOOR_DWELL;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			send_word(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].want);
			pace_sender();
		end

		// Each phase changes both timing registers while the block is idle.
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_timing(CFG_FLOOR_DWELL, dwell_set[p]);
			write_timing(CFG_DOOR_OPEN, open_set[p]);
			settings_used++;
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				send_word(next_word(), 1'b0, UNTYPED);
				pace_sender();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d words (%0d with effect) under %0d timing settings.",
			words_sent, live_words, settings_used);
		$display("Checked %0d results; %0d of 25 states visited; %0d failures.",
			results_seen, $countones(states_seen), fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
